FILE: rtl/rau_pkg.sv
package rau_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Divider operand pairs: gcd remainder step, numerator / g, denominator / g
    typedef enum logic [1:0] {
        DSEL_GCD = 2'd0,
        DSEL_NUM = 2'd1,
        DSEL_DEN = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul1;
        logic     mul2;
        logic     mul3;
        logic     init_gcd;
        logic     set_err;
        logic     div_start;
        div_sel_t div_sel;
        logic     gcd_step;
        logic     take_num;
        logic     take_den;
    } rau_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic den_zero;
        logic n_zero;
        logic div_done;
    } rau_stat_t;

endpackage

FILE: rtl/rau_dp.sv
module rau_dp
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rau_cmd_t           cmd,
    output rau_stat_t          stat,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic               status
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [1:0]   op_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] t1_reg, t2_reg, num_reg, den_reg;
    logic [W-1:0] m_reg, n_reg, rn_reg, rd_reg;
    logic         err_reg;

    logic [W-1:0] mul_a, mul_b, prod;

    // Shared iterative divider (restoring, one quotient bit per cycle)
    logic [W-1:0]  rem_reg, quo_reg, dvs_reg;
    logic          qneg_reg, rneg_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [W-1:0]  dvd_sel, dvs_sel, dvd_mag, dvs_mag;
    logic [W:0]    shifted, diff;
    logic [W-1:0]  q_final, r_final;

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        if (cmd.mul1)
        begin
            mul_a = an_reg;
            mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
        end
        else if (cmd.mul2)
        begin
            mul_a = bn_reg;
            mul_b = ad_reg;
        end
        else if (cmd.mul3)
        begin
            mul_a = ad_reg;
            mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
        end
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_GCD:
            begin
                dvd_sel = m_reg;
                dvs_sel = n_reg;
            end
            DSEL_NUM:
            begin
                dvd_sel = num_reg;
                dvs_sel = m_reg;
            end
            DSEL_DEN:
            begin
                dvd_sel = den_reg;
                dvs_sel = m_reg;
            end
            default:
            begin
                dvd_sel = m_reg;
                dvs_sel = n_reg;
            end
        endcase
    end

    assign dvd_mag = dvd_sel[W-1] ? (~dvd_sel + 1'b1) : dvd_sel;
    assign dvs_mag = dvs_sel[W-1] ? (~dvs_sel + 1'b1) : dvs_sel;
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign q_final = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign r_final = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.div_start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            if (cmd.set_err)
                err_reg <= 1'b1;
            else if (cmd.take_den)
                err_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            an_reg <= W'(a_num);
            ad_reg <= W'(a_den);
            bn_reg <= W'(b_num);
            bd_reg <= W'(b_den);
        end
        if (cmd.mul1)
            t1_reg <= prod;
        if (cmd.mul2)
            t2_reg <= prod;
        if (cmd.mul3)
        begin
            den_reg <= prod;
            case (op_reg)
                OP_ADD:  num_reg <= t1_reg + t2_reg;
                OP_SUB:  num_reg <= t1_reg - t2_reg;
                default: num_reg <= t1_reg;
            endcase
        end
        if (cmd.init_gcd)
        begin
            m_reg <= num_reg;
            n_reg <= den_reg;
        end
        else if (cmd.gcd_step)
        begin
            m_reg <= n_reg;
            n_reg <= r_final;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dvd_mag;
            dvs_reg  <= dvs_mag;
            qneg_reg <= dvd_sel[W-1] ^ dvs_sel[W-1];
            rneg_reg <= dvd_sel[W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ~diff[W]};
        end
        if (cmd.set_err)
        begin
            rn_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            if (cmd.take_num)
                rn_reg <= q_final;
            if (cmd.take_den)
                rd_reg <= q_final;
        end
    end

    assign stat.in_zero  = (ad_reg == '0) || (bd_reg == '0);
    assign stat.den_zero = (den_reg == '0);
    assign stat.n_zero   = (n_reg == '0);
    assign stat.div_done = done_reg;

    assign res_num = 32'(signed'(rn_reg));
    assign res_den = 32'(signed'(rd_reg));
    assign status  = err_reg;

endmodule

FILE: rtl/rau_ctrl.sv
module rau_ctrl
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  rau_stat_t stat,
    output rau_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL1  = 10'b0000000010,
        S_MUL2  = 10'b0000000100,
        S_MUL3  = 10'b0000001000,
        S_CHECK = 10'b0000010000,
        S_GTEST = 10'b0000100000,
        S_GDIV  = 10'b0001000000,
        S_QNUM  = 10'b0010000000,
        S_QDEN  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DSEL_GCD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.in_zero || stat.den_zero)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.init_gcd = 1'b1;
                    state_next   = S_GTEST;
                end
            end
            S_GTEST:
            begin
                cmd.div_start = 1'b1;
                if (stat.n_zero)
                begin
                    cmd.div_sel = DSEL_NUM;
                    state_next  = S_QNUM;
                end
                else
                begin
                    state_next = S_GDIV;
                end
            end
            S_GDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.gcd_step = 1'b1;
                    state_next   = S_GTEST;
                end
            end
            S_QNUM:
            begin
                if (stat.div_done)
                begin
                    cmd.take_num  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_DEN;
                    state_next    = S_QDEN;
                end
            end
            S_QDEN:
            begin
                if (stat.div_done)
                begin
                    cmd.take_den = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

endmodule

FILE: rtl/rational_arith_unit.sv
// Result path: on a zero-denominator error the result follows the multiply slots and the
// zero check directly; otherwise it also waits for the Euclid remainder steps on the divider
// (at most about 1.44 * WORD_BITS of them) and the two reducing divisions.
// Throughput: one word at a time; the next input word is taken only after the result
// word has left. Most of the work falls on the shared one-bit-per-cycle divider.
// Reset (rst_n, asynchronous, active low) returns the controller to idle, no result held.
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic               status
);

    rau_cmd_t  cmd;
    rau_stat_t stat;

    // Sequencer: load, three multiply slots on one multiplier, zero check (a zero
    // denominator ends there), Euclid loop on the divider, then the two reducing divisions.
    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Operand registers, multiplier, gcd registers and the shared divider;
    // the result registers hold the word steady while out_valid waits.
    rau_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .opcode  (opcode),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .res_num (res_num),
        .res_den (res_den),
        .status  (status)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (res_num == 32'sd0 && res_den == 32'sd0))
        else $error("error result carries nonzero fields");

    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !status) |-> (res_den != 32'sd0))
        else $error("good result with zero denominator");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");
`endif

endmodule

FILE: verif/tb.sv
module tb;
    import rau_pkg::*;

    localparam int WORD_BITS = 32;
    localparam int N_RANDOM  = 1850;
    // slowest word: ~48 Euclid steps plus worst stalls, then
    // taken several times over
    localparam longint CYCLE_LIMIT = 64'd24_000_000;
    localparam logic signed [31:0] MAX_W = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN_W = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic               status;
    } frac_res_t;

    // Truncating signed remainder and quotient, built from magnitudes so the
    // most negative word divided by minus one wraps instead of trapping.
    function automatic longint unsigned mag_of(logic [31:0] v);
        return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    function automatic logic [31:0] trunc_rem(logic [31:0] m, logic [31:0] n);
        longint unsigned dm;
        longint unsigned r;
        dm = mag_of(n);
        if (dm == 0)
            return 32'd0;
        r = mag_of(m) % dm;
        return m[31] ? 32'(64'd0 - r) : 32'(r);
    endfunction

    function automatic logic [31:0] trunc_quo(logic [31:0] m, logic [31:0] n);
        longint unsigned dm;
        longint unsigned q;
        dm = mag_of(n);
        if (dm == 0)
            return 32'd0;
        q = mag_of(m) / dm;
        return (m[31] != n[31]) ? 32'(64'd0 - q) : 32'(q);
    endfunction

    class frac_scoreboard;
        frac_res_t pending[$];
        frac_res_t last_exp;

        // compute the reduced fraction for an accepted word and hold it
        function void note_word(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
            logic [31:0] n, d, g, m, t;
            frac_res_t e;
            e = '{num: 0, den: 0, status: 1'b1};
            if (ad != 0 && bd != 0)
            begin
                case (op)
                    OP_ADD:
                    begin
                        n = an * bd + bn * ad;
                        d = ad * bd;
                    end
                    OP_SUB:
                    begin
                        n = an * bd - bn * ad;
                        d = ad * bd;
                    end
                    OP_MUL:
                    begin
                        n = an * bn;
                        d = ad * bd;
                    end
                    default:
                    begin
                        n = an * bd;
                        d = ad * bn;
                    end
                endcase
                if (d != 0)
                begin
                    m = n;
                    g = d;
                    while (g != 0)
                    begin
                        t = trunc_rem(m, g);
                        m = g;
                        g = t;
                    end
                    e.num = trunc_quo(n, m);
                    e.den = trunc_quo(d, m);
                    e.status = 1'b0;
                end
            end
            pending.push_back(e);
        endfunction

        // 0 match, 1 nothing waiting, 2 field mismatch
        function int check_word(frac_res_t got);
            if (pending.size() == 0)
                return 1;
            last_exp = pending.pop_front();
            return (got === last_exp) ? 0 : 2;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic signed [31:0] a_num, a_den, b_num, b_den;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] res_num, res_den;
    logic               status;

    frac_scoreboard sb;
    int     n_errors;
    int     n_words_in;
    int     n_words_out;
    int     n_err_status;
    longint cycles;

    rational_arith_unit #(.WORD_BITS(WORD_BITS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .res_num  (res_num),
        .res_den  (res_den),
        .status   (status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // print one line per mismatch and count it
    task automatic report(string what);
        n_errors++;
        $display("tb: MISMATCH %s", what);
    endtask

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // drive one word at the falling edge and hold it until accepted
    task automatic send_word(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode   <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // random operand: small values most often, full range, extremes, or small values shifted left
    function automatic logic [31:0] pick_val(bit allow_zero);
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 45)
            v = 32'($signed($urandom_range(0, 400)) - 200);
        else if (r < 85)
            v = $urandom;
        else if (r < 92)
            v = ($urandom_range(0, 1) != 0) ? MAX_W : MIN_W;
        else
            v = 32'($urandom_range(1, 16)) << $urandom_range(0, 20);
        if (v == 0 && !allow_zero)
            v = 32'd1;
        return v;
    endfunction

    // sample both channels at the rising edge; DUT outputs are still old here
    always @(posedge clk)
    begin
        int rc;
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_word(opcode, a_num, a_den, b_num, b_den);
            n_words_in++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            rc = sb.check_word('{num: res_num, den: res_den, status: status});
            n_words_out++;
            if (status)
                n_err_status++;
            if (rc == 1)
                report($sformatf("result word %0d with none expected", n_words_out));
            else if (rc == 2)
                report($sformatf("word %0d got %0d/%0d st %0b, exp %0d/%0d st %0b",
                    n_words_out, res_num, res_den, status, sb.last_exp.num,
                    sb.last_exp.den, sb.last_exp.status));
        end
    end

    // receiver: stall for a random spell, then stay ready until a word leaves
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        int streak;
        logic [1:0] op;
        sb = new();
        n_errors = 0;
        n_words_in = 0;
        n_words_out = 0;
        n_err_status = 0;
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_ADD;
        a_num = 0;
        a_den = 1;
        b_num = 0;
        b_den = 1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: each operation, extremes, zero denominators
        send_word(OP_ADD, 1, 2, 1, 3, 0);
        send_word(OP_SUB, 1, 2, 1, 3, 0);
        send_word(OP_MUL, 2, 3, 9, 4, 1);
        send_word(OP_DIV, 2, 3, 9, 4, 0);
        send_word(OP_ADD, 5, 0, 1, 1, 0);        // left denominator zero
        send_word(OP_MUL, 5, 7, 1, 0, 2);        // right denominator zero
        send_word(OP_DIV, 0, 0, 0, 0, 0);
        send_word(OP_DIV, 3, 4, 0, 5, 0);        // divide by a zero fraction
        send_word(OP_MUL, 1, 32'h10000, 1, 32'h10000, 0); // denominator wraps to zero
        send_word(OP_ADD, 3, 32'h8000, 1, 32'h20000, 0);
        send_word(OP_MUL, MIN_W, -1, 1, 1, 0);   // most negative over minus one
        send_word(OP_DIV, MIN_W, 1, -1, 1, 3);
        send_word(OP_MUL, MAX_W, MAX_W, MAX_W, MAX_W, 0);
        send_word(OP_ADD, MIN_W, MIN_W, MIN_W, MIN_W, 0);
        send_word(OP_SUB, MAX_W, MIN_W, MIN_W, MAX_W, 0);
        send_word(OP_SUB, 7, 9, 7, 9, 0);        // zero numerator
        send_word(OP_MUL, -6, 4, 3, -9, 0);
        send_word(OP_DIV, -1, -1, -1, -1, 0);
        send_word(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_fffe, 32'h1, 0);
        send_word(OP_MUL, 0, MIN_W, 0, MAX_W, 0);

        // random words; some runs go back to back
        streak = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            op = 2'($urandom_range(0, 3));
            if (streak == 0 && $urandom_range(0, 19) == 0)
                streak = $urandom_range(5, 20);
            if (i == N_RANDOM / 2)
            begin
                // drain the block before continuing
                in_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(negedge clk);
            end
            send_word(op, pick_val(1),
                      pick_val($urandom_range(0, 30) == 0),
                      pick_val(1),
                      pick_val($urandom_range(0, 30) == 0),
                      (streak > 0) ? 0 : pick_gap());
            if (streak > 0)
                streak--;
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        $display("tb: %0d words in, %0d results out, %0d with error status",
                 n_words_in, n_words_out, n_err_status);
        $display("tb: covered all four operations, zero and wrapped denominators");
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/rau_pkg.sv
rtl/rau_dp.sv
rtl/rau_ctrl.sv
rtl/rational_arith_unit.sv
verif/tb.sv
